>>> sv/altitude_velocity_kalman_filter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the altitude/velocity Kalman filter
// Shared property wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ALTITUDE_VELOCITY_KALMAN_FILTER_MACROS_SVH
`define ALTITUDE_VELOCITY_KALMAN_FILTER_MACROS_SVH

// same-cycle implication
`define AVKF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AVKF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/avkf_pkg.sv
// ----------------------------------------------------------------------------
// avkf_pkg
// Types, constants and helpers for the altitude/velocity Kalman filter.
// ----------------------------------------------------------------------------
package avkf_pkg;

  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [1:0] {
    CFG_ACCEL_VAR = 2'd0,
    CFG_BARO_VAR  = 2'd1,
    CFG_INIT_ALT  = 2'd2,
    CFG_INIT_VEL  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_RND,
    S_ACC,
    S_CHECK,
    S_DIV,
    S_DIVEND,
    S_OUT
  } state_t;

  // operand / destination registers of the shared unit
  typedef enum logic [4:0] {
    R_ZERO, R_DT, R_ACC, R_BARO, R_VA,
    R_ALT, R_VEL, R_C0, R_C1, R_C2, R_C3,
    R_B0, R_M, R_Q00, R_Q01, R_Q11, R_TMP,
    R_ALTP, R_VELP, R_T00, R_T01,
    R_PP00, R_PP01, R_PP10, R_PP11,
    R_K0, R_K1, R_Y
  } reg_id_t;

  // dst = x +/- y +/- sat(round(a*b >> sh))
  typedef struct packed {
    reg_id_t a;
    reg_id_t b;
    reg_id_t x;
    reg_id_t y;
    logic    neg_y;
    logic    neg_p;
    logic    sh1;
    reg_id_t dst;
  } uop_t;

  typedef logic [4:0] step_t;

  localparam step_t STEP_LAST_PRED  = 5'd17;
  localparam step_t STEP_FIRST_CORR = 5'd18;
  localparam step_t STEP_LAST       = 5'd24;

  function automatic uop_t mk_uop(reg_id_t a, reg_id_t b, reg_id_t x, reg_id_t y,
                                  logic neg_y, logic neg_p, logic sh1, reg_id_t dst);
    uop_t u;
    u.a = a; u.b = b; u.x = x; u.y = y;
    u.neg_y = neg_y; u.neg_p = neg_p; u.sh1 = sh1; u.dst = dst;
    return u;
  endfunction

  function automatic logic [31:0] sat66(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -66'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> sv/altitude_velocity_kalman_filter.sv
// ----------------------------------------------------------------------------
// altitude_velocity_kalman_filter
// Two-state (altitude, vertical velocity) Kalman filter, fixed point.
// ----------------------------------------------------------------------------
// Each input transfer runs one predict/correct step through a single shared
// multiply-round-saturate-accumulate unit (multiply, round and accumulate
// states per micro-op, 18 prediction ops and 7 correction ops) and one
// bit-serial divider that forms the two gains, each followed by a finishing
// state. There is also one check state after the prediction; when the
// innovation variance is zero, the divider and the correction are skipped.
// The result then waits for out_tready. in_tready returns in the cycle after
// the output transfer, so no new input is taken while a step or its result
// is pending. Writing initial altitude or velocity loads the state;
// covariance resets to zero.
`include "altitude_velocity_kalman_filter_macros.svh"

module altitude_velocity_kalman_filter #(
  parameter int FRAC_BITS = avkf_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // time_step[15:0], vertical_accel, baro_altitude
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // est_altitude[31:0], est_velocity
  output logic [0:0]  out_tuser   // corrected
);

  localparam int DW   = 32 + FRAC_BITS;
  localparam int CNTW = $clog2(DW + 1);
  localparam logic signed [65:0] RND0 = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [65:0] RND1 = 66'sd1 <<< FRAC_BITS;

  avkf_pkg::state_t state_r, state_nxt;
  avkf_pkg::step_t  step_r;
  avkf_pkg::uop_t   uop;

  logic [31:0] va_r, bv_r;
  logic [31:0] dt_r, acc_r, baro_r;
  logic [31:0] alt_r, vel_r, c0_r, c1_r, c2_r, c3_r;
  logic [31:0] b0_r, m_r, q00_r, q01_r, q11_r, tmp_r;
  logic [31:0] altp_r, velp_r, t00_r, t01_r;
  logic [31:0] pp00_r, pp01_r, pp10_r, pp11_r, k0_r, k1_r, y_r;
  logic        corr_r;

  logic signed [65:0] prod_r;
  logic [31:0]        pterm_r;

  logic [32:0]     div_rem_r, div_d_r;
  logic [DW-1:0]   div_q_r;
  logic [CNTW-1:0] div_cnt_r;
  logic            div_neg_r, div_sel_r, s_neg_r;

  logic accept_in, accept_out;
  assign accept_in  = in_tvalid && in_tready;
  assign accept_out = out_tvalid && out_tready;

  function automatic logic signed [32:0] rd(avkf_pkg::reg_id_t sel);
    logic [32:0] v;
    case (sel)
      avkf_pkg::R_ZERO: v = '0;
      avkf_pkg::R_DT:   v = {1'b0, dt_r};
      avkf_pkg::R_ACC:  v = {acc_r[31], acc_r};
      avkf_pkg::R_BARO: v = {baro_r[31], baro_r};
      avkf_pkg::R_VA:   v = {1'b0, va_r};
      avkf_pkg::R_ALT:  v = {alt_r[31], alt_r};
      avkf_pkg::R_VEL:  v = {vel_r[31], vel_r};
      avkf_pkg::R_C0:   v = {c0_r[31], c0_r};
      avkf_pkg::R_C1:   v = {c1_r[31], c1_r};
      avkf_pkg::R_C2:   v = {c2_r[31], c2_r};
      avkf_pkg::R_C3:   v = {c3_r[31], c3_r};
      avkf_pkg::R_B0:   v = {b0_r[31], b0_r};
      avkf_pkg::R_M:    v = {m_r[31], m_r};
      avkf_pkg::R_Q00:  v = {q00_r[31], q00_r};
      avkf_pkg::R_Q01:  v = {q01_r[31], q01_r};
      avkf_pkg::R_Q11:  v = {q11_r[31], q11_r};
      avkf_pkg::R_TMP:  v = {tmp_r[31], tmp_r};
      avkf_pkg::R_ALTP: v = {altp_r[31], altp_r};
      avkf_pkg::R_VELP: v = {velp_r[31], velp_r};
      avkf_pkg::R_T00:  v = {t00_r[31], t00_r};
      avkf_pkg::R_T01:  v = {t01_r[31], t01_r};
      avkf_pkg::R_PP00: v = {pp00_r[31], pp00_r};
      avkf_pkg::R_PP01: v = {pp01_r[31], pp01_r};
      avkf_pkg::R_PP10: v = {pp10_r[31], pp10_r};
      avkf_pkg::R_PP11: v = {pp11_r[31], pp11_r};
      avkf_pkg::R_K0:   v = {k0_r[31], k0_r};
      avkf_pkg::R_K1:   v = {k1_r[31], k1_r};
      avkf_pkg::R_Y:    v = {y_r[31], y_r};
      default:          v = '0;
    endcase
    return $signed(v);
  endfunction

  // micro-program
  always_comb begin
    uop = avkf_pkg::mk_uop(avkf_pkg::R_ZERO, avkf_pkg::R_ZERO, avkf_pkg::R_ZERO,
                           avkf_pkg::R_ZERO, 1'b0, 1'b0, 1'b0, avkf_pkg::R_ZERO);
    case (step_r)
      5'd0:  uop = avkf_pkg::mk_uop(avkf_pkg::R_DT, avkf_pkg::R_DT, avkf_pkg::R_ZERO,
                                    avkf_pkg::R_ZERO, 1'b0, 1'b0, 1'b1, avkf_pkg::R_B0);
      5'd1:  uop = avkf_pkg::mk_uop(avkf_pkg::R_B0, avkf_pkg::R_B0, avkf_pkg::R_ZERO,
                                    avkf_pkg::R_ZERO, 1'b0, 1'b0, 1'b0, avkf_pkg::R_M);
      5'd2:  uop = avkf_pkg::mk_uop(avkf_pkg::R_M, avkf_pkg::R_VA, avkf_pkg::R_ZERO,
                                    avkf_pkg::R_ZERO, 1'b0, 1'b0, 1'b0, avkf_pkg::R_Q00);
      5'd3:  uop = avkf_pkg::mk_uop(avkf_pkg::R_B0, avkf_pkg::R_DT, avkf_pkg::R_ZERO,
                                    avkf_pkg::R_ZERO, 1'b0, 1'b0, 1'b0, avkf_pkg::R_M);
      5'd4:  uop = avkf_pkg::mk_uop(avkf_pkg::R_M, avkf_pkg::R_VA, avkf_pkg::R_ZERO,
                                    avkf_pkg::R_ZERO, 1'b0, 1'b0, 1'b0, avkf_pkg::R_Q01);
      5'd5:  uop = avkf_pkg::mk_uop(avkf_pkg::R_DT, avkf_pkg::R_DT, avkf_pkg::R_ZERO,
                                    avkf_pkg::R_ZERO, 1'b0, 1'b0, 1'b0, avkf_pkg::R_M);
      5'd6:  uop = avkf_pkg::mk_uop(avkf_pkg::R_M, avkf_pkg::R_VA, avkf_pkg::R_ZERO,
                                    avkf_pkg::R_ZERO, 1'b0, 1'b0, 1'b0, avkf_pkg::R_Q11);
      5'd7:  uop = avkf_pkg::mk_uop(avkf_pkg::R_DT, avkf_pkg::R_VEL, avkf_pkg::R_ZERO,
                                    avkf_pkg::R_ZERO, 1'b0, 1'b0, 1'b0, avkf_pkg::R_TMP);
      5'd8:  uop = avkf_pkg::mk_uop(avkf_pkg::R_B0, avkf_pkg::R_ACC, avkf_pkg::R_ALT,
                                    avkf_pkg::R_TMP, 1'b0, 1'b0, 1'b0, avkf_pkg::R_ALTP);
      5'd9:  uop = avkf_pkg::mk_uop(avkf_pkg::R_DT, avkf_pkg::R_ACC, avkf_pkg::R_VEL,
                                    avkf_pkg::R_ZERO, 1'b0, 1'b0, 1'b0, avkf_pkg::R_VELP);
      5'd10: uop = avkf_pkg::mk_uop(avkf_pkg::R_DT, avkf_pkg::R_C2, avkf_pkg::R_C0,
                                    avkf_pkg::R_ZERO, 1'b0, 1'b0, 1'b0, avkf_pkg::R_T00);
      5'd11: uop = avkf_pkg::mk_uop(avkf_pkg::R_DT, avkf_pkg::R_C3, avkf_pkg::R_C1,
                                    avkf_pkg::R_ZERO, 1'b0, 1'b0, 1'b0, avkf_pkg::R_T01);
      5'd12: uop = avkf_pkg::mk_uop(avkf_pkg::R_T01, avkf_pkg::R_DT, avkf_pkg::R_T00,
                                    avkf_pkg::R_ZERO, 1'b0, 1'b0, 1'b0, avkf_pkg::R_TMP);
      5'd13: uop = avkf_pkg::mk_uop(avkf_pkg::R_ZERO, avkf_pkg::R_ZERO, avkf_pkg::R_TMP,
                                    avkf_pkg::R_Q00, 1'b0, 1'b0, 1'b0, avkf_pkg::R_PP00);
      5'd14: uop = avkf_pkg::mk_uop(avkf_pkg::R_ZERO, avkf_pkg::R_ZERO, avkf_pkg::R_T01,
                                    avkf_pkg::R_Q01, 1'b0, 1'b0, 1'b0, avkf_pkg::R_PP01);
      5'd15: uop = avkf_pkg::mk_uop(avkf_pkg::R_C3, avkf_pkg::R_DT, avkf_pkg::R_C2,
                                    avkf_pkg::R_ZERO, 1'b0, 1'b0, 1'b0, avkf_pkg::R_TMP);
      5'd16: uop = avkf_pkg::mk_uop(avkf_pkg::R_ZERO, avkf_pkg::R_ZERO, avkf_pkg::R_TMP,
                                    avkf_pkg::R_Q01, 1'b0, 1'b0, 1'b0, avkf_pkg::R_PP10);
      5'd17: uop = avkf_pkg::mk_uop(avkf_pkg::R_ZERO, avkf_pkg::R_ZERO, avkf_pkg::R_C3,
                                    avkf_pkg::R_Q11, 1'b0, 1'b0, 1'b0, avkf_pkg::R_PP11);
      5'd18: uop = avkf_pkg::mk_uop(avkf_pkg::R_ZERO, avkf_pkg::R_ZERO, avkf_pkg::R_BARO,
                                    avkf_pkg::R_ALTP, 1'b1, 1'b0, 1'b0, avkf_pkg::R_Y);
      5'd19: uop = avkf_pkg::mk_uop(avkf_pkg::R_K0, avkf_pkg::R_Y, avkf_pkg::R_ALTP,
                                    avkf_pkg::R_ZERO, 1'b0, 1'b0, 1'b0, avkf_pkg::R_ALT);
      5'd20: uop = avkf_pkg::mk_uop(avkf_pkg::R_K1, avkf_pkg::R_Y, avkf_pkg::R_VELP,
                                    avkf_pkg::R_ZERO, 1'b0, 1'b0, 1'b0, avkf_pkg::R_VEL);
      5'd21: uop = avkf_pkg::mk_uop(avkf_pkg::R_K0, avkf_pkg::R_PP00, avkf_pkg::R_PP00,
                                    avkf_pkg::R_ZERO, 1'b0, 1'b1, 1'b0, avkf_pkg::R_C0);
      5'd22: uop = avkf_pkg::mk_uop(avkf_pkg::R_K0, avkf_pkg::R_PP01, avkf_pkg::R_PP01,
                                    avkf_pkg::R_ZERO, 1'b0, 1'b1, 1'b0, avkf_pkg::R_C1);
      5'd23: uop = avkf_pkg::mk_uop(avkf_pkg::R_K1, avkf_pkg::R_PP00, avkf_pkg::R_PP10,
                                    avkf_pkg::R_ZERO, 1'b0, 1'b1, 1'b0, avkf_pkg::R_C2);
      5'd24: uop = avkf_pkg::mk_uop(avkf_pkg::R_K1, avkf_pkg::R_PP01, avkf_pkg::R_PP11,
                                    avkf_pkg::R_ZERO, 1'b0, 1'b1, 1'b0, avkf_pkg::R_C3);
      default: ;
    endcase
  end

  // shared datapath
  logic signed [32:0] opa, opb, opx, opy;
  logic signed [65:0] rnd_v, shf_v;
  logic signed [34:0] ty, tp, sum_v;
  logic [31:0]        res_v;
  logic signed [33:0] s_v;
  logic               s_zero;
  logic [47:0]        dt_wide;
  logic [33:0]        trial;
  logic               trial_ge;
  logic signed [DW:0] qs_v;
  logic [31:0]        k_v;

  always_comb begin
    opa   = rd(uop.a);
    opb   = rd(uop.b);
    opx   = rd(uop.x);
    opy   = rd(uop.y);
    rnd_v = prod_r + (uop.sh1 ? RND1 : RND0);
    shf_v = uop.sh1 ? (rnd_v >>> (FRAC_BITS + 1)) : (rnd_v >>> FRAC_BITS);
    ty    = uop.neg_y ? -35'(opy) : 35'(opy);
    tp    = uop.neg_p ? -35'($signed(pterm_r)) : 35'($signed(pterm_r));
    sum_v = 35'(opx) + ty + tp;
    res_v = avkf_pkg::sat66(66'(sum_v));
    s_v    = 34'($signed(pp00_r)) + $signed({2'b00, bv_r});
    s_zero = (s_v == '0);
    dt_wide = (48'(in_tdata[15:0]) << FRAC_BITS) >> 16;
    trial    = {div_rem_r, div_q_r[DW-1]};
    trial_ge = (trial >= {1'b0, div_d_r});
    qs_v = div_neg_r ? -$signed({1'b0, div_q_r}) : $signed({1'b0, div_q_r});
    k_v  = avkf_pkg::sat66(66'(qs_v));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      avkf_pkg::S_IDLE:   if (accept_in) state_nxt = avkf_pkg::S_MUL;
      avkf_pkg::S_MUL:    state_nxt = avkf_pkg::S_RND;
      avkf_pkg::S_RND:    state_nxt = avkf_pkg::S_ACC;
      avkf_pkg::S_ACC: begin
        if (step_r == avkf_pkg::STEP_LAST_PRED) state_nxt = avkf_pkg::S_CHECK;
        else if (step_r == avkf_pkg::STEP_LAST) state_nxt = avkf_pkg::S_OUT;
        else state_nxt = avkf_pkg::S_MUL;
      end
      avkf_pkg::S_CHECK:  state_nxt = s_zero ? avkf_pkg::S_OUT : avkf_pkg::S_DIV;
      avkf_pkg::S_DIV:    if (div_cnt_r == CNTW'(DW - 1)) state_nxt = avkf_pkg::S_DIVEND;
      avkf_pkg::S_DIVEND: state_nxt = div_sel_r ? avkf_pkg::S_MUL : avkf_pkg::S_DIV;
      avkf_pkg::S_OUT:    if (accept_out) state_nxt = avkf_pkg::S_IDLE;
      default:            state_nxt = avkf_pkg::S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_tready  = (state_r == avkf_pkg::S_IDLE);
    out_tvalid = (state_r == avkf_pkg::S_OUT);
    out_tdata  = {vel_r, alt_r};
    out_tuser  = corr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= avkf_pkg::S_IDLE;
      step_r  <= '0;
      va_r    <= '0;
      bv_r    <= '0;
      alt_r   <= '0;
      vel_r   <= '0;
      c0_r    <= '0;
      c1_r    <= '0;
      c2_r    <= '0;
      c3_r    <= '0;
      corr_r  <= 1'b0;
      div_sel_r <= 1'b0;
      div_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (avkf_pkg::cfg_idx_t'(cfg_addr))
          avkf_pkg::CFG_ACCEL_VAR: va_r  <= cfg_wdata;
          avkf_pkg::CFG_BARO_VAR:  bv_r  <= cfg_wdata;
          avkf_pkg::CFG_INIT_ALT:  alt_r <= cfg_wdata;
          avkf_pkg::CFG_INIT_VEL:  vel_r <= cfg_wdata;
          default: ;
        endcase
      end
      case (state_r)
        avkf_pkg::S_IDLE: begin
          if (accept_in) begin
            dt_r   <= dt_wide[31:0];
            acc_r  <= in_tdata[47:16];
            baro_r <= in_tdata[79:48];
            step_r <= '0;
          end
        end
        avkf_pkg::S_MUL: prod_r  <= opa * opb;
        avkf_pkg::S_RND: pterm_r <= avkf_pkg::sat66(shf_v);
        avkf_pkg::S_ACC: begin
          step_r <= step_r + 5'd1;
          if (step_r == avkf_pkg::STEP_LAST) corr_r <= 1'b1;
          case (uop.dst)
            avkf_pkg::R_ALT:  alt_r  <= res_v;
            avkf_pkg::R_VEL:  vel_r  <= res_v;
            avkf_pkg::R_C0:   c0_r   <= res_v;
            avkf_pkg::R_C1:   c1_r   <= res_v;
            avkf_pkg::R_C2:   c2_r   <= res_v;
            avkf_pkg::R_C3:   c3_r   <= res_v;
            avkf_pkg::R_B0:   b0_r   <= res_v;
            avkf_pkg::R_M:    m_r    <= res_v;
            avkf_pkg::R_Q00:  q00_r  <= res_v;
            avkf_pkg::R_Q01:  q01_r  <= res_v;
            avkf_pkg::R_Q11:  q11_r  <= res_v;
            avkf_pkg::R_TMP:  tmp_r  <= res_v;
            avkf_pkg::R_ALTP: altp_r <= res_v;
            avkf_pkg::R_VELP: velp_r <= res_v;
            avkf_pkg::R_T00:  t00_r  <= res_v;
            avkf_pkg::R_T01:  t01_r  <= res_v;
            avkf_pkg::R_PP00: pp00_r <= res_v;
            avkf_pkg::R_PP01: pp01_r <= res_v;
            avkf_pkg::R_PP10: pp10_r <= res_v;
            avkf_pkg::R_PP11: pp11_r <= res_v;
            avkf_pkg::R_Y:    y_r    <= res_v;
            default: ;
          endcase
        end
        avkf_pkg::S_CHECK: begin
          if (s_zero) begin
            // no correction: take prediction, covariance untouched
            alt_r  <= altp_r;
            vel_r  <= velp_r;
            corr_r <= 1'b0;
          end else begin
            div_d_r   <= s_v[33] ? 33'(-s_v) : s_v[32:0];
            s_neg_r   <= s_v[33];
            div_sel_r <= 1'b0;
            div_cnt_r <= '0;
            div_rem_r <= '0;
            div_q_r   <= {pp00_r[31] ? 32'(-pp00_r) : pp00_r, {FRAC_BITS{1'b0}}};
            div_neg_r <= pp00_r[31] ^ s_v[33];
          end
        end
        avkf_pkg::S_DIV: begin
          div_cnt_r <= div_cnt_r + CNTW'(1);
          div_rem_r <= trial_ge ? 33'(trial - {1'b0, div_d_r}) : trial[32:0];
          div_q_r   <= {div_q_r[DW-2:0], trial_ge};
        end
        avkf_pkg::S_DIVEND: begin
          if (div_sel_r) begin
            k1_r   <= k_v;
            step_r <= avkf_pkg::STEP_FIRST_CORR;
          end else begin
            // second gain: same divisor, numerator pp10
            k0_r      <= k_v;
            div_sel_r <= 1'b1;
            div_cnt_r <= '0;
            div_rem_r <= '0;
            div_q_r   <= {pp10_r[31] ? 32'(-pp10_r) : pp10_r, {FRAC_BITS{1'b0}}};
            div_neg_r <= pp10_r[31] ^ s_neg_r;
          end
        end
        default: ;
      endcase
    end
  end

  `AVKF_ASSERT_IMPL(a_excl, out_tvalid, !in_tready, "input ready while result pending")
  `AVKF_ASSERT_IMPL(a_step, state_r == avkf_pkg::S_MUL,
                    step_r <= avkf_pkg::STEP_LAST, "step out of range")
  `AVKF_ASSERT_NEXT(a_ret, accept_out, in_tready, "not idle after result transfer")
  `AVKF_ASSERT_NEXT(a_skip, state_r == avkf_pkg::S_CHECK && s_zero,
                    $stable(c0_r) && $stable(c3_r) && !corr_r,
                    "skipped correction changed state")

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// Altitude/velocity Kalman filter testbench
// Drives sensor steps and register writes into the filter and checks every
// estimate against a built-in fixed-point predictor of the predict/correct step.
// ----------------------------------------------------------------------------
typedef struct {
  logic [31:0] alt;
  logic [31:0] vel;
  logic        corr;
} estimate_t;

class estimate_board;
  estimate_t pending[$];
  int        errors;
  int        checked;
  int        n_corr;

  function void note_step(estimate_t e);
    pending.push_back(e);
  endfunction

  task report(string msg);
    errors++;
    $display("%s", msg);
  endtask

  task check_result(logic [31:0] alt, logic [31:0] vel, logic corr);
    estimate_t e;
    if (pending.size() == 0) begin
      report($sformatf("unexpected result alt=%h vel=%h corr=%b", alt, vel, corr));
      return;
    end
    e = pending.pop_front();
    checked++;
    if (corr) n_corr++;
    if (alt !== e.alt || vel !== e.vel || corr !== e.corr)
      report($sformatf("mismatch #%0d: got %h %h %b exp %h %h %b",
                       checked, alt, vel, corr, e.alt, e.vel, e.corr));
  endtask
endclass

module tb_top;
  localparam int FB = avkf_pkg::FRAC_BITS_DEF;
  localparam int N_RANDOM = 1700;
  localparam longint CYCLE_LIMIT = 2000000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [31:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [0:0]  out_tuser;

  altitude_velocity_kalman_filter dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  estimate_board board = new();

  // predictor state
  logic [31:0]        va_q, bv_q;
  logic signed [31:0] alt_q, vel_q;
  logic signed [31:0] cov_q [4];

  bit     idle_enable = 1;
  bit     hold_out    = 0;
  longint cycles      = 0;
  int     n_zero_s    = 0;
  int     out_idle    = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic logic signed [31:0] clamp(logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -66'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // round-half-up product, arithmetic shift, saturate; operands given as 33-bit signed
  function automatic logic signed [31:0] rmul(logic signed [32:0] a, logic signed [32:0] b,
                                              int sh);
    logic signed [65:0] p;
    p = a * b;
    p = p + (66'sd1 <<< (sh - 1));
    return clamp(p >>> sh);
  endfunction

  function automatic logic signed [32:0] s33(logic signed [31:0] v);
    return {v[31], v};
  endfunction

  function automatic estimate_t filter_step(logic [15:0] ts, logic signed [31:0] acc,
                                            logic signed [31:0] baro);
    logic signed [32:0] dt, va;
    logic signed [31:0] b0, b1, q00, q01, q11, alt_p, vel_p, t00, t01;
    logic signed [31:0] pp00, pp01, pp10, pp11, k0, k1, y;
    logic signed [65:0] s, num;
    estimate_t e;
    dt = ({17'd0, ts} << FB) >>> 16;
    va = {1'b0, va_q};
    b0 = rmul(dt, dt, FB + 1);
    b1 = dt[31:0];
    q00 = rmul(s33(rmul(s33(b0), s33(b0), FB)), va, FB);
    q01 = rmul(s33(rmul(s33(b0), s33(b1), FB)), va, FB);
    q11 = rmul(s33(rmul(s33(b1), s33(b1), FB)), va, FB);
    alt_p = clamp(66'(alt_q) + 66'(rmul(dt, s33(vel_q), FB))
                  + 66'(rmul(s33(b0), s33(acc), FB)));
    vel_p = clamp(66'(vel_q) + 66'(rmul(dt, s33(acc), FB)));
    t00 = clamp(66'(cov_q[0]) + 66'(rmul(dt, s33(cov_q[2]), FB)));
    t01 = clamp(66'(cov_q[1]) + 66'(rmul(dt, s33(cov_q[3]), FB)));
    pp00 = clamp(66'(clamp(66'(t00) + 66'(rmul(s33(t01), dt, FB)))) + 66'(q00));
    pp01 = clamp(66'(t01) + 66'(q01));
    pp10 = clamp(66'(clamp(66'(cov_q[2]) + 66'(rmul(s33(cov_q[3]), dt, FB)))) + 66'(q01));
    pp11 = clamp(66'(cov_q[3]) + 66'(q11));
    s = 66'(pp00) + $signed({34'd0, bv_q});
    if (s != 0) begin
      num = 66'(pp00) <<< FB;
      k0 = clamp(num / s);
      num = 66'(pp10) <<< FB;
      k1 = clamp(num / s);
      y = clamp(66'(baro) - 66'(alt_p));
      alt_q = clamp(66'(alt_p) + 66'(rmul(s33(k0), s33(y), FB)));
      vel_q = clamp(66'(vel_p) + 66'(rmul(s33(k1), s33(y), FB)));
      cov_q[0] = clamp(66'(pp00) - 66'(rmul(s33(k0), s33(pp00), FB)));
      cov_q[1] = clamp(66'(pp01) - 66'(rmul(s33(k0), s33(pp01), FB)));
      cov_q[2] = clamp(66'(pp10) - 66'(rmul(s33(k1), s33(pp00), FB)));
      cov_q[3] = clamp(66'(pp11) - 66'(rmul(s33(k1), s33(pp01), FB)));
      e.corr = 1;
    end else begin
      alt_q = alt_p;
      vel_q = vel_p;
      e.corr = 0;
    end
    e.alt = alt_q;
    e.vel = vel_q;
    return e;
  endfunction

  task automatic write_reg(avkf_pkg::cfg_idx_t idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      avkf_pkg::CFG_ACCEL_VAR: va_q = val;
      avkf_pkg::CFG_BARO_VAR:  bv_q = val;
      avkf_pkg::CFG_INIT_ALT:  alt_q = val;
      avkf_pkg::CFG_INIT_VEL:  vel_q = val;
      default: ;
    endcase
  endtask

  // in_tvalid stays up after a transfer; the next step or drain decides
  task automatic send_step(logic [15:0] ts, logic [31:0] acc, logic [31:0] baro);
    estimate_t e;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {baro, acc, ts};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    e = filter_step(ts, acc, baro);
    if (!e.corr) n_zero_s++;
    board.note_step(e);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    in_tvalid <= 0;
    while (board.pending.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (250) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_val(int style);
    case (style)
      0: return $urandom();
      1: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      default: return $urandom_range(0, 32'h0001_0000);
    endcase
  endfunction

  // receiver: random stall bursts plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else if (hold_out) out_tready <= 0;
    else if (out_idle > 0) begin
      out_tready <= 0;
      out_idle <= out_idle - 1;
    end else if (idle_enable && $urandom_range(0, 4) == 0) begin
      out_tready <= 0;
      out_idle <= $urandom_range(0, 4);
    end else out_tready <= 1;
    if (rst_n && out_tvalid && out_tready)
      board.check_result(out_tdata[31:0], out_tdata[63:32], out_tuser[0]);
  end

  initial begin
    int i;
    logic [15:0] ts_edge [4];
    rst_n = 0;
    cfg_we = 0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_tvalid = 0;
    in_tdata = '0;
    va_q = 0; bv_q = 0; alt_q = 0; vel_q = 0;
    for (i = 0; i < 4; i++) cov_q[i] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // all-zero registers: innovation variance zero, correction skipped
    send_step(16'h0000, 32'h0000_0000, 32'h0000_0000);
    send_step(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_step(16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    drain();
    write_reg(avkf_pkg::CFG_INIT_ALT, 32'h7FFF_FFFF);
    write_reg(avkf_pkg::CFG_INIT_VEL, 32'h8000_0000);
    send_step(16'hFFFF, 32'h7FFF_FFFF, 32'h0000_0000);
    drain();
    write_reg(avkf_pkg::CFG_ACCEL_VAR, 32'hFFFF_FFFF);
    write_reg(avkf_pkg::CFG_BARO_VAR, 32'hFFFF_FFFF);
    ts_edge = '{16'h0000, 16'h0001, 16'h8000, 16'hFFFF};
    for (i = 0; i < 8; i++)
      send_step(ts_edge[i[1:0]], i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF,
                i[1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    drain();
    write_reg(avkf_pkg::CFG_ACCEL_VAR, 32'h0001_0000);
    write_reg(avkf_pkg::CFG_BARO_VAR, 32'h0000_0000);
    write_reg(avkf_pkg::CFG_INIT_ALT, 32'h0000_0000);
    write_reg(avkf_pkg::CFG_INIT_VEL, 32'h0000_0000);
    for (i = 0; i < 6; i++) send_step(16'h0CCD, 32'h0001_0000, 32'h0064_0000);
    drain();

    // long receiver hold-off while steps keep coming
    fork
      begin
        hold_out = 1;
        repeat (800) @(posedge clk);
        hold_out = 0;
      end
      for (int k = 0; k < 6; k++) send_step(16'($urandom()), rand_val(1), rand_val(1));
    join
    drain();

    // random phases with fresh register settings
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: write_reg(avkf_pkg::CFG_ACCEL_VAR, $urandom_range(0, 32'h0004_0000));
        1: write_reg(avkf_pkg::CFG_ACCEL_VAR, $urandom());
        2: write_reg(avkf_pkg::CFG_ACCEL_VAR, 32'h0);
        default: write_reg(avkf_pkg::CFG_ACCEL_VAR, 32'hFFFF_FFFF);
      endcase
      case (ph % 3)
        0: write_reg(avkf_pkg::CFG_BARO_VAR, $urandom_range(0, 32'h0004_0000));
        1: write_reg(avkf_pkg::CFG_BARO_VAR, $urandom());
        default: write_reg(avkf_pkg::CFG_BARO_VAR, 32'h0);
      endcase
      if (ph % 2 == 0) begin
        write_reg(avkf_pkg::CFG_INIT_ALT, rand_val(ph % 3));
        write_reg(avkf_pkg::CFG_INIT_VEL, rand_val(ph % 3));
      end
      if (ph == 8) idle_enable = 0;
      for (i = 0; i < N_RANDOM / 10; i++)
        send_step(16'(($urandom_range(0, 7) == 0) ? $urandom()
                                                  : $urandom_range(0, 16'h0800)),
                  rand_val($urandom_range(0, 2)), rand_val($urandom_range(0, 2)));
      drain();
    end

    $display("checked %0d estimates, %0d corrected, %0d with zero innovation variance",
             board.checked, board.n_corr, n_zero_s);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("%0d errors, %0d estimates never arrived", board.errors,
               board.pending.size());
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+sv
sv/avkf_pkg.sv
sv/altitude_velocity_kalman_filter.sv
bench/tb_top.sv
